>>> rtl/tatc_pkg.sv
`default_nettype none

package tatc_pkg;

  // Widths of the item fields and of the configuration port.
  localparam int unsigned LightW   = 20;
  localparam int unsigned PosW     = 16;
  localparam int unsigned BandW    = 21;
  localparam int unsigned CfgDataW = 21;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ActionW  = 3;

  // Position bounds of the two axes, the reset position and the ends of the signed range.
  localparam logic signed [PosW-1:0] HorizPosHi = 16'sd90;
  localparam logic signed [PosW-1:0] HorizPosLo = 16'sd30;
  localparam logic signed [PosW-1:0] VertPosHi  = 16'sd180;
  localparam logic signed [PosW-1:0] VertPosLo  = 16'sd0;
  localparam logic signed [PosW-1:0] PosReset   = 16'sd1000;
  localparam logic signed [PosW-1:0] PosMax     = 16'sh7fff;
  localparam logic signed [PosW-1:0] PosMin     = 16'sh8000;

  // Request action codes.
  typedef enum logic [ActionW-1:0] {
    ACT_EVAL   = 3'd0,
    ACT_HOME   = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_STEP_H = 3'd3,
    ACT_STEP_V = 3'd4
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MANUAL     = 3'd0,
    CFG_H_SETPOINT = 3'd1,
    CFG_V_SETPOINT = 3'd2,
    CFG_BAND_UPPER = 3'd3,
    CFG_BAND_LOWER = 3'd4
  } cfg_idx_e;

  // Configuration register contents.
  typedef struct packed {
    logic                    manual;
    logic signed [PosW-1:0]  h_setpoint;
    logic signed [PosW-1:0]  v_setpoint;
    logic signed [BandW-1:0] band_upper;
    logic signed [BandW-1:0] band_lower;
  } cfg_t;

  // Per-axis command decoded from the action code.
  typedef struct packed {
    logic eval;
    logic home;
    logic stop;
    logic step;
  } axis_cmd_t;

  // State of one axis.
  typedef struct packed {
    logic                   run;
    logic                   dir;
    logic signed [PosW-1:0] pos;
  } axis_state_t;

  // One accepted request as held in the input register.
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [LightW-1:0]  light_top;
    logic [LightW-1:0]  light_bottom;
    logic [LightW-1:0]  light_left;
    logic [LightW-1:0]  light_right;
    logic               switch_horiz_low;
    logic               switch_horiz_high;
    logic               switch_vert;
  } in_item_t;

endpackage

`default_nettype wire

>>> rtl/two_axis_light_tracker_control_unit.sv
// Two-axis light tracker control.
//
// Requests enter on in_valid_i / in_stall_o with one port per field and are
// accepted at a rising edge where in_valid_i is high and in_stall_o is low.
// Every request yields exactly one result on out_valid_o / out_stall_i: the
// run flags, directions and positions of both axes after that request.
// The user writes one configuration register per edge via cfg_we_i, cfg_idx_i
// and cfg_data_i, only while no request is in flight; the block does not check.
//
// A request is taken into the input register; when it moves on, the axis
// decision logic updates the axis state registers, which are the result
// register. One request is accepted per cycle while out_stall_i is low.
// While the receiver stalls, the result holds and one more request may
// wait in the input register; after that in_stall_o goes high.
// Reset clears the configuration, stops both axes, points them toward the
// top and the left, and sets both positions to 1000. No result is pending.
`default_nettype none

module two_axis_light_tracker_control_unit
  import tatc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration port.
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [CfgDataW-1:0]    cfg_data_i,
  // Request channel.
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [ActionW-1:0]     action_i,
  input  wire logic [LightW-1:0]      light_top_i,
  input  wire logic [LightW-1:0]      light_bottom_i,
  input  wire logic [LightW-1:0]      light_left_i,
  input  wire logic [LightW-1:0]      light_right_i,
  input  wire logic                   switch_horiz_low_i,
  input  wire logic                   switch_horiz_high_i,
  input  wire logic                   switch_vert_i,
  // Result channel.
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        horiz_running_o,
  output logic                        horiz_toward_top_o,
  output logic                        vert_running_o,
  output logic                        vert_toward_left_o,
  output logic signed [PosW-1:0]      horiz_pos_out_o,
  output logic signed [PosW-1:0]      vert_pos_out_o
);

  cfg_t        cfg;
  in_item_t    in_q;
  logic        in_vld_q;
  logic        out_vld_q;
  logic        advance;
  logic        in_take;
  axis_cmd_t   h_cmd;
  axis_cmd_t   v_cmd;
  axis_state_t h_q;
  axis_state_t h_d;
  axis_state_t v_q;
  axis_state_t v_d;

  tatc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: the held request moves on when the result slot is free or drains.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.action            <= action_i;
      in_q.light_top         <= light_top_i;
      in_q.light_bottom      <= light_bottom_i;
      in_q.light_left        <= light_left_i;
      in_q.light_right       <= light_right_i;
      in_q.switch_horiz_low  <= switch_horiz_low_i;
      in_q.switch_horiz_high <= switch_horiz_high_i;
      in_q.switch_vert       <= switch_vert_i;
    end
  end

  // Action decoder.
  always_comb begin
    h_cmd = '0;
    v_cmd = '0;
    unique case (action_e'(in_q.action))
      ACT_EVAL: begin
        h_cmd.eval = 1'b1;
        v_cmd.eval = 1'b1;
      end
      ACT_HOME: begin
        h_cmd.home = 1'b1;
        v_cmd.home = 1'b1;
      end
      ACT_STOP: begin
        h_cmd.stop = 1'b1;
        v_cmd.stop = 1'b1;
      end
      ACT_STEP_H: h_cmd.step = 1'b1;
      ACT_STEP_V: v_cmd.step = 1'b1;
      default: ;
    endcase
  end

  // Horizontal axis: top against bottom, homes toward the bottom switch.
  tatc_axis u_horiz (
    .cmd_i        (h_cmd),
    .manual_i     (cfg.manual),
    .band_upper_i (cfg.band_upper),
    .band_lower_i (cfg.band_lower),
    .setpoint_i   (cfg.h_setpoint),
    .light_a_i    (in_q.light_top),
    .light_b_i    (in_q.light_bottom),
    .sw_up_i      (in_q.switch_horiz_high),
    .sw_down_i    (in_q.switch_horiz_low),
    .sw_home_i    (in_q.switch_horiz_low),
    .home_dir_i   (1'b0),
    .pos_hi_i     (HorizPosHi),
    .pos_lo_i     (HorizPosLo),
    .state_i      (h_q),
    .state_o      (h_d)
  );

  // Vertical axis: left against right, no switch on the way to the right.
  tatc_axis u_vert (
    .cmd_i        (v_cmd),
    .manual_i     (cfg.manual),
    .band_upper_i (cfg.band_upper),
    .band_lower_i (cfg.band_lower),
    .setpoint_i   (cfg.v_setpoint),
    .light_a_i    (in_q.light_left),
    .light_b_i    (in_q.light_right),
    .sw_up_i      (in_q.switch_vert),
    .sw_down_i    (1'b1),
    .sw_home_i    (in_q.switch_vert),
    .home_dir_i   (1'b1),
    .pos_hi_i     (VertPosHi),
    .pos_lo_i     (VertPosLo),
    .state_i      (v_q),
    .state_o      (v_d)
  );

  // Axis state doubles as the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      h_q.run   <= 1'b0;
      h_q.dir   <= 1'b1;
      h_q.pos   <= PosReset;
      v_q.run   <= 1'b0;
      v_q.dir   <= 1'b1;
      v_q.pos   <= PosReset;
    end else begin
      if (advance) begin
        out_vld_q <= 1'b1;
        h_q       <= h_d;
        v_q       <= v_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_vld_q;
  assign horiz_running_o    = h_q.run;
  assign horiz_toward_top_o = h_q.dir;
  assign vert_running_o     = v_q.run;
  assign vert_toward_left_o = v_q.dir;
  assign horiz_pos_out_o    = h_q.pos;
  assign vert_pos_out_o     = v_q.pos;

endmodule

`default_nettype wire

>>> rtl/tatc_cfg.sv
`default_nettype none

module tatc_cfg
  import tatc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MANUAL:     cfg_q.manual     <= cfg_data_i[0];
        CFG_H_SETPOINT: cfg_q.h_setpoint <= cfg_data_i[PosW-1:0];
        CFG_V_SETPOINT: cfg_q.v_setpoint <= cfg_data_i[PosW-1:0];
        CFG_BAND_UPPER: cfg_q.band_upper <= cfg_data_i[BandW-1:0];
        CFG_BAND_LOWER: cfg_q.band_lower <= cfg_data_i[BandW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/tatc_axis.sv
`default_nettype none

module tatc_axis
  import tatc_pkg::*;
(
  input  axis_cmd_t                    cmd_i,
  input  wire logic                    manual_i,
  input  wire logic signed [BandW-1:0] band_upper_i,
  input  wire logic signed [BandW-1:0] band_lower_i,
  input  wire logic signed [PosW-1:0]  setpoint_i,
  input  wire logic [LightW-1:0]       light_a_i,
  input  wire logic [LightW-1:0]       light_b_i,
  input  wire logic                    sw_up_i,
  input  wire logic                    sw_down_i,
  input  wire logic                    sw_home_i,
  input  wire logic                    home_dir_i,
  input  wire logic signed [PosW-1:0]  pos_hi_i,
  input  wire logic signed [PosW-1:0]  pos_lo_i,
  input  axis_state_t                  state_i,
  output axis_state_t                  state_o
);

  logic signed [BandW-1:0] diff;
  logic                    in_band;
  logic                    up_ok;
  logic                    down_ok;

  // Light difference; both sides are 20-bit unsigned, so it fits 21 bits signed.
  assign diff    = $signed({1'b0, light_a_i}) - $signed({1'b0, light_b_i});
  assign in_band = (diff < band_upper_i) && (diff > band_lower_i);
  assign up_ok   = (light_b_i > light_a_i) && sw_up_i && (state_i.pos < pos_hi_i);
  assign down_ok = (light_b_i < light_a_i) && sw_down_i && (state_i.pos > pos_lo_i);

  // Next state of the axis. A stopped axis keeps its direction.
  always_comb begin
    state_o = state_i;
    if (cmd_i.eval) begin
      if (manual_i) begin
        if (state_i.pos == setpoint_i) begin
          state_o.run = 1'b0;
        end else if ((state_i.pos < setpoint_i) && (state_i.pos < pos_hi_i)) begin
          state_o.run = 1'b1;
          state_o.dir = 1'b1;
        end else if ((state_i.pos > setpoint_i) && (state_i.pos > pos_lo_i)) begin
          state_o.run = 1'b1;
          state_o.dir = 1'b0;
        end else begin
          state_o.run = 1'b0;
        end
      end else begin
        if (in_band) begin
          state_o.run = 1'b0;
        end else if (up_ok) begin
          state_o.run = 1'b1;
          state_o.dir = 1'b1;
        end else if (down_ok) begin
          state_o.run = 1'b1;
          state_o.dir = 1'b0;
        end else begin
          state_o.run = 1'b0;
        end
      end
    end else if (cmd_i.home) begin
      state_o.run = sw_home_i;
      if (sw_home_i) begin
        state_o.dir = home_dir_i;
      end
    end else if (cmd_i.stop) begin
      state_o.run = 1'b0;
    end else if (cmd_i.step) begin
      // Saturating step in the stored direction.
      if (state_i.dir) begin
        if (state_i.pos != PosMax) begin
          state_o.pos = state_i.pos + 16'sd1;
        end
      end else begin
        if (state_i.pos != PosMin) begin
          state_o.pos = state_i.pos - 16'sd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tatc_checker.sv
`default_nettype none

module tatc_checker
  import tatc_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic                  horiz_running_o,
  input wire logic                  horiz_toward_top_o,
  input wire logic                  vert_running_o,
  input wire logic                  vert_toward_left_o,
  input wire logic signed [PosW-1:0] horiz_pos_out_o,
  input wire logic signed [PosW-1:0] vert_pos_out_o
);

  logic next_result;

  // A result is taken in this cycle.
  assign next_result = out_valid_o && !out_stall_i;

  // A stalled result holds all of its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(horiz_pos_out_o) && $stable(vert_pos_out_o) &&
      $stable(horiz_running_o) && $stable(vert_running_o) &&
      $stable(horiz_toward_top_o) && $stable(vert_toward_left_o))
    else $error("stalled result changed");

  // With the result slot empty, the request side never stalls.
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled while no result is pending");

  // Consecutive results differ by at most one step in each position.
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_result ##1 out_valid_o |->
      (horiz_pos_out_o == $past(horiz_pos_out_o) ||
       horiz_pos_out_o == $past(horiz_pos_out_o) + 16'sd1 ||
       horiz_pos_out_o == $past(horiz_pos_out_o) - 16'sd1) &&
      (vert_pos_out_o == $past(vert_pos_out_o) ||
       vert_pos_out_o == $past(vert_pos_out_o) + 16'sd1 ||
       vert_pos_out_o == $past(vert_pos_out_o) - 16'sd1))
    else $error("position jumped between results");

  // A single request never moves both axes.
  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_result ##1 out_valid_o |->
      (horiz_pos_out_o == $past(horiz_pos_out_o) ||
       vert_pos_out_o == $past(vert_pos_out_o)))
    else $error("both positions moved on one request");

  // A step pulse leaves run flags and directions alone.
  a_step_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_result ##1 (out_valid_o &&
      (horiz_pos_out_o != $past(horiz_pos_out_o) ||
       vert_pos_out_o != $past(vert_pos_out_o))) |->
      $stable(horiz_running_o) && $stable(vert_running_o) &&
      $stable(horiz_toward_top_o) && $stable(vert_toward_left_o))
    else $error("step pulse changed run flag or direction");

endmodule

bind two_axis_light_tracker_control_unit tatc_checker u_tatc_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tatc_pkg::*;

  localparam int LightMax   = (1 << LightW) - 1;
  localparam int BandMax    = (1 << (BandW - 1)) - 1;
  localparam int BandMin    = -(1 << (BandW - 1));
  localparam int HoldCycles = 30;
  localparam int CycleLimit = 100_000;

  // Block ports; the inputs are driven to known values from time zero.
  logic                   clk_i               = 1'b0;
  logic                   rst_ni              = 1'b0;
  logic                   cfg_we_i            = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i           = '0;
  logic [CfgDataW-1:0]    cfg_data_i          = '0;
  logic                   in_valid_i          = 1'b0;
  logic                   in_stall_o;
  logic [ActionW-1:0]     action_i            = '0;
  logic [LightW-1:0]      light_top_i         = '0;
  logic [LightW-1:0]      light_bottom_i      = '0;
  logic [LightW-1:0]      light_left_i        = '0;
  logic [LightW-1:0]      light_right_i       = '0;
  logic                   switch_horiz_low_i  = 1'b1;
  logic                   switch_horiz_high_i = 1'b1;
  logic                   switch_vert_i       = 1'b1;
  logic                   out_valid_o;
  logic                   out_stall_i         = 1'b0;
  logic                   horiz_running_o;
  logic                   horiz_toward_top_o;
  logic                   vert_running_o;
  logic                   vert_toward_left_o;
  logic signed [PosW-1:0] horiz_pos_out_o;
  logic signed [PosW-1:0] vert_pos_out_o;

  // Expected state of both axes after one request.
  typedef struct packed {
    axis_state_t horiz;
    axis_state_t vert;
  } tracker_view_t;

  // Predicted axis state and the configuration as the block should hold it.
  axis_state_t   horiz_axis;
  axis_state_t   vert_axis;
  logic          manual_seek;
  int            h_setpoint;
  int            v_setpoint;
  int            band_upper_ohms;
  int            band_lower_ohms;
  tracker_view_t expected_axes[$];

  bit idling_on     = 1'b0;
  bit hold_request  = 1'b0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  two_axis_light_tracker_control_unit u_top (.*);

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort the run if it hangs.
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("MISMATCH cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
    end
  endtask

  // Move a position one step, holding at the ends of the signed range.
  function automatic logic signed [PosW-1:0] step_position(logic signed [PosW-1:0] pos,
                                                           logic up);
    if (up) begin
      return (pos == PosMax) ? pos : pos + 16'sd1;
    end
    return (pos == PosMin) ? pos : pos - 16'sd1;
  endfunction

  // Automatic mode: stop inside the dead band, else move toward the side with the lower reading.
  function automatic void seek_light(input int diff, input logic up_ok, input logic down_ok,
                                     inout axis_state_t axis);
    if (diff < band_upper_ohms && diff > band_lower_ohms) begin
      axis.run = 1'b0;
    end else if (up_ok) begin
      axis.run = 1'b1;
      axis.dir = 1'b1;
    end else if (down_ok) begin
      axis.run = 1'b1;
      axis.dir = 1'b0;
    end else begin
      axis.run = 1'b0;
    end
  endfunction

  // Manual mode: move toward the setpoint while inside the axis bounds.
  function automatic void seek_setpoint(input int setpoint, input logic signed [PosW-1:0] hi,
                                        input logic signed [PosW-1:0] lo,
                                        inout axis_state_t axis);
    if (axis.pos == setpoint) begin
      axis.run = 1'b0;
    end else if (axis.pos < setpoint && axis.pos < hi) begin
      axis.run = 1'b1;
      axis.dir = 1'b1;
    end else if (axis.pos > setpoint && axis.pos > lo) begin
      axis.run = 1'b1;
      axis.dir = 1'b0;
    end else begin
      axis.run = 1'b0;
    end
  endfunction

  // Apply one accepted request to the predicted state and queue the result.
  function automatic void track_request(in_item_t req);
    int top_minus_bottom;
    int left_minus_right;
    top_minus_bottom = int'(req.light_top) - int'(req.light_bottom);
    left_minus_right = int'(req.light_left) - int'(req.light_right);
    case (req.action)
      ACT_EVAL: begin
        if (manual_seek) begin
          seek_setpoint(h_setpoint, HorizPosHi, HorizPosLo, horiz_axis);
          seek_setpoint(v_setpoint, VertPosHi, VertPosLo, vert_axis);
        end else begin
          seek_light(top_minus_bottom,
                     req.light_bottom > req.light_top && req.switch_horiz_high &&
                       horiz_axis.pos < HorizPosHi,
                     req.light_bottom < req.light_top && req.switch_horiz_low &&
                       horiz_axis.pos > HorizPosLo,
                     horiz_axis);
          // The vertical axis checks no switch when moving right.
          seek_light(left_minus_right,
                     req.light_left < req.light_right && req.switch_vert &&
                       vert_axis.pos < VertPosHi,
                     req.light_left > req.light_right && vert_axis.pos > VertPosLo,
                     vert_axis);
        end
      end
      ACT_HOME: begin
        horiz_axis.run = req.switch_horiz_low;
        if (req.switch_horiz_low) horiz_axis.dir = 1'b0;
        vert_axis.run = req.switch_vert;
        if (req.switch_vert) vert_axis.dir = 1'b1;
      end
      ACT_STOP: begin
        horiz_axis.run = 1'b0;
        vert_axis.run  = 1'b0;
      end
      ACT_STEP_H: horiz_axis.pos = step_position(horiz_axis.pos, horiz_axis.dir);
      ACT_STEP_V: vert_axis.pos = step_position(vert_axis.pos, vert_axis.dir);
      default: begin
      end
    endcase
    expected_axes.push_back({horiz_axis, vert_axis});
  endfunction

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    tracker_view_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_axes.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 1);
      end else begin
        want = expected_axes.pop_front();
        if (horiz_running_o !== want.horiz.run)
          report_mismatch("horiz_running", want.horiz.run, horiz_running_o);
        if (horiz_toward_top_o !== want.horiz.dir)
          report_mismatch("horiz_toward_top", want.horiz.dir, horiz_toward_top_o);
        if (vert_running_o !== want.vert.run)
          report_mismatch("vert_running", want.vert.run, vert_running_o);
        if (vert_toward_left_o !== want.vert.dir)
          report_mismatch("vert_toward_left", want.vert.dir, vert_toward_left_o);
        if (horiz_pos_out_o !== want.horiz.pos)
          report_mismatch("horiz_pos_out", want.horiz.pos, horiz_pos_out_o);
        if (vert_pos_out_o !== want.vert.pos)
          report_mismatch("vert_pos_out", want.vert.pos, vert_pos_out_o);
      end
    end
  end

  // Result side: random stall bursts, and a long hold-off when asked.
  initial begin : result_stall
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one request, with an occasional gap first, and wait until it is taken.
  task automatic send_request(in_item_t req);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    action_i            <= req.action;
    light_top_i         <= req.light_top;
    light_bottom_i      <= req.light_bottom;
    light_left_i        <= req.light_left;
    light_right_i       <= req.light_right;
    switch_horiz_low_i  <= req.switch_horiz_low;
    switch_horiz_high_i <= req.switch_horiz_high;
    switch_vert_i       <= req.switch_vert;
    do @(posedge clk_i); while (in_stall_o);
    track_request(req);
  endtask

  // Stop offering requests and wait until every result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_axes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MANUAL:     manual_seek = value[0];
      CFG_H_SETPOINT: h_setpoint = $signed(value[PosW-1:0]);
      CFG_V_SETPOINT: v_setpoint = $signed(value[PosW-1:0]);
      CFG_BAND_UPPER: band_upper_ohms = $signed(value[BandW-1:0]);
      CFG_BAND_LOWER: band_lower_ohms = $signed(value[BandW-1:0]);
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  // Switches are given as {horizontal low, horizontal high, vertical}.
  function automatic in_item_t make_request(logic [ActionW-1:0] action, int top, int bottom,
                                            int left, int right, logic [2:0] switches);
    in_item_t req;
    req.action       = action;
    req.light_top    = top[LightW-1:0];
    req.light_bottom = bottom[LightW-1:0];
    req.light_left   = left[LightW-1:0];
    req.light_right  = right[LightW-1:0];
    {req.switch_horiz_low, req.switch_horiz_high, req.switch_vert} = switches;
    return req;
  endfunction

  // A photoresistor pair: independent, equal, extreme, or straddling a band edge.
  function automatic logic [2*LightW-1:0] light_pair();
    logic [LightW-1:0] first;
    logic [LightW-1:0] second;
    int                sum;
    second = LightW'($urandom);
    case ($urandom_range(0, 4))
      0: first = LightW'($urandom);
      1: first = second;
      2: begin
        first  = LightW'($urandom_range(0, 1) ? LightMax : 0);
        second = LightW'($urandom_range(0, 1) ? LightMax : 0);
      end
      default: begin
        sum = int'(second) + ($urandom_range(0, 1) ? band_upper_ohms : band_lower_ohms) +
              int'($urandom_range(0, 2)) - 1;
        first = (sum < 0 || sum > LightMax) ? LightW'($urandom) : sum[LightW-1:0];
      end
    endcase
    return {first, second};
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) req.action = ACT_EVAL;
    else if (pick < 50) req.action = ACT_HOME;
    else if (pick < 57) req.action = ACT_STOP;
    else if (pick < 77) req.action = ACT_STEP_H;
    else if (pick < 96) req.action = ACT_STEP_V;
    else req.action = ActionW'($urandom_range(ACT_STEP_V + 1, (1 << ActionW) - 1));
    {req.light_top, req.light_bottom} = light_pair();
    {req.light_left, req.light_right} = light_pair();
    req.switch_horiz_low  = $urandom_range(0, 3) != 0;
    req.switch_horiz_high = $urandom_range(0, 3) != 0;
    req.switch_vert       = $urandom_range(0, 3) != 0;
    return req;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_request(random_request());
  endtask

  // Step both axes until they reach the goals, then step some more.
  task automatic walk_axes(logic signed [PosW-1:0] horiz_goal,
                           logic signed [PosW-1:0] vert_goal, int extra);
    while (horiz_axis.pos != horiz_goal || vert_axis.pos != vert_goal) begin
      if (horiz_axis.pos != horiz_goal)
        send_request(make_request(ACT_STEP_H, 0, 0, 0, 0, 3'b111));
      if (vert_axis.pos != vert_goal)
        send_request(make_request(ACT_STEP_V, 0, 0, 0, 0, 3'b111));
    end
    repeat (extra) begin
      send_request(make_request(ACT_STEP_H, 0, 0, 0, 0, 3'b111));
      send_request(make_request(ACT_STEP_V, 0, 0, 0, 0, 3'b111));
    end
  endtask

  // Registers at reset values, positions far above the tracking bounds.
  task automatic test_reset_behavior();
    send_request(make_request(ACT_EVAL, 0, 0, 0, 0, 3'b111));
    send_request(make_request(ACT_EVAL, LightMax, 0, 0, LightMax, 3'b111));
    send_request(make_request(ACT_EVAL, 0, LightMax, LightMax, 0, 3'b000));
    send_request(make_request(ACT_HOME, 0, 0, 0, 0, 3'b111));
    send_request(make_request(ACT_HOME, 0, 0, 0, 0, 3'b010));
    send_request(make_request(ACT_HOME, 0, 0, 0, 0, 3'b101));
    send_request(make_request(ACT_STOP, LightMax, LightMax, LightMax, LightMax, 3'b111));
    for (int code = ACT_STEP_V + 1; code < (1 << ActionW); code++) begin
      send_request(make_request(code[ActionW-1:0], LightMax, 0, LightMax, 0, 3'b111));
    end
    send_request(make_request(ACT_STEP_H, 0, 0, 0, 0, 3'b111));
    send_request(make_request(ACT_STEP_V, 0, 0, 0, 0, 3'b111));
  endtask

  // Step both axes down a few positions, then home; horizontal steps on down, vertical back up.
  task automatic test_position_steps();
    idling_on = 1'b0;
    send_request(make_request(ACT_EVAL, 1, 0, 1, 0, 3'b111));
    walk_axes(horiz_axis.pos - 16'sd6, vert_axis.pos - 16'sd6, 2);
    send_request(make_request(ACT_HOME, 0, 0, 0, 0, 3'b111));
    walk_axes(horiz_axis.pos - 16'sd4, vert_axis.pos + 16'sd10, 0);
    idling_on = 1'b1;
  endtask

  // Dead band edges, position bounds and limit switches in automatic mode.
  task automatic test_auto_tracking();
    drain_results();
    write_reg(CFG_BAND_UPPER, 100);
    write_reg(CFG_BAND_LOWER, -50);
    send_request(make_request(ACT_EVAL, 1100, 1000, 1000, 1050, 3'b111));
    send_request(make_request(ACT_EVAL, 1099, 1000, 1000, 1049, 3'b111));
    send_request(make_request(ACT_EVAL, 0, LightMax, LightMax, 0, 3'b111));
    send_request(make_request(ACT_STEP_H, 0, 0, 0, 0, 3'b111));
    send_request(make_request(ACT_STEP_V, 0, 0, 0, 0, 3'b111));
    send_request(make_request(ACT_EVAL, 0, LightMax, 0, LightMax, 3'b101));
    send_request(make_request(ACT_EVAL, 0, LightMax, 0, LightMax, 3'b110));
    send_request(make_request(ACT_EVAL, 0, LightMax, 0, LightMax, 3'b111));
    send_request(make_request(ACT_EVAL, LightMax, 0, LightMax, 0, 3'b011));
    send_request(make_request(ACT_EVAL, LightMax, 0, LightMax, 0, 3'b000));
    send_request(make_request(ACT_EVAL, 500, 500, 7, 7, 3'b111));
    // An inverted band never holds an axis.
    drain_results();
    write_reg(CFG_BAND_UPPER, -50);
    write_reg(CFG_BAND_LOWER, 100);
    send_request(make_request(ACT_EVAL, 1000, 1000, 1000, 1000, 3'b111));
    send_request(make_request(ACT_EVAL, 1010, 1000, 1000, 1010, 3'b111));
  endtask

  // Manual setpoints within the bounds, at the extremes and at the current position.
  task automatic test_manual_seek();
    drain_results();
    write_reg(CFG_MANUAL, 1);
    write_reg(CFG_H_SETPOINT, 60);
    write_reg(CFG_V_SETPOINT, 0);
    send_request(make_request(ACT_EVAL, 0, 0, 0, 0, 3'b111));
    send_request(make_request(ACT_STEP_H, 0, 0, 0, 0, 3'b111));
    send_request(make_request(ACT_EVAL, LightMax, 0, 0, LightMax, 3'b000));
    drain_results();
    write_reg(CFG_H_SETPOINT, PosMax);
    write_reg(CFG_V_SETPOINT, PosMax);
    send_request(make_request(ACT_EVAL, 0, 0, 0, 0, 3'b111));
    drain_results();
    write_reg(CFG_H_SETPOINT, PosMin);
    write_reg(CFG_V_SETPOINT, PosMin);
    send_request(make_request(ACT_EVAL, 0, 0, 0, 0, 3'b111));
    drain_results();
    write_reg(CFG_H_SETPOINT, horiz_axis.pos);
    write_reg(CFG_V_SETPOINT, vert_axis.pos);
    send_request(make_request(ACT_EVAL, 0, 0, 0, 0, 3'b111));
    send_request(make_request(ACT_STEP_V, 0, 0, 0, 0, 3'b111));
    send_request(make_request(ACT_EVAL, 0, 0, 0, 0, 3'b111));
  endtask

  // The receiver holds off while requests keep coming, so the input backs up.
  task automatic test_receiver_hold_off();
    hold_request = 1'b1;
    run_random(12);
    drain_results();
  endtask

  // Random requests under several automatic mode bands.
  task automatic test_random_auto();
    drain_results();
    write_reg(CFG_MANUAL, 0);
    write_reg(CFG_BAND_UPPER, 200);
    write_reg(CFG_BAND_LOWER, -200);
    run_random(100);
    drain_results();
    write_reg(CFG_BAND_UPPER, BandMax);
    write_reg(CFG_BAND_LOWER, BandMin);
    run_random(80);
    drain_results();
    write_reg(CFG_BAND_UPPER, -300);
    write_reg(CFG_BAND_LOWER, 300);
    run_random(50);
    // The sender pauses here until every result is back.
    drain_results();
    run_random(50);
  endtask

  // Random requests in manual mode, setpoints around the bounds and at the extremes.
  task automatic test_random_manual();
    drain_results();
    write_reg(CFG_MANUAL, 1);
    write_reg(CFG_H_SETPOINT, int'($urandom_range(0, 120)) - 10);
    write_reg(CFG_V_SETPOINT, int'($urandom_range(0, 200)) - 10);
    run_random(100);
    drain_results();
    write_reg(CFG_H_SETPOINT, PosMin);
    write_reg(CFG_V_SETPOINT, PosMax);
    run_random(60);
  endtask

  // Closing stretch with both sides always ready.
  task automatic test_steady_tail();
    drain_results();
    idling_on = 1'b0;
    write_reg(CFG_MANUAL, 0);
    write_reg(CFG_BAND_UPPER, int'($urandom_range(0, 500)));
    write_reg(CFG_BAND_LOWER, -int'($urandom_range(0, 500)));
    run_random(150);
  endtask

  initial begin : stimulus
    horiz_axis      = '{run: 1'b0, dir: 1'b1, pos: PosReset};
    vert_axis       = '{run: 1'b0, dir: 1'b1, pos: PosReset};
    manual_seek     = 1'b0;
    h_setpoint      = 0;
    v_setpoint      = 0;
    band_upper_ohms = 0;
    band_lower_ohms = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idling_on = 1'b1;

    test_reset_behavior();
    test_position_steps();
    test_auto_tracking();
    test_manual_seek();
    test_receiver_hold_off();
    test_random_auto();
    test_random_manual();
    test_steady_tail();
    drain_results();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tatc_pkg.sv
rtl/tatc_cfg.sv
rtl/tatc_axis.sv
rtl/two_axis_light_tracker_control_unit.sv
rtl/tatc_checker.sv
tb/testbench.sv
